// ===== sv/least_squares_line_fit_assert.svh =====
// Assertion macros used by the least-squares line fit top level
`ifndef LEAST_SQUARES_LINE_FIT_ASSERT_SVH
`define LEAST_SQUARES_LINE_FIT_ASSERT_SVH

// Check that cons holds in the same cycle as ante
`define LSLF_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("lslf: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define LSLF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("lslf: next-cycle check failed");

`endif

// ===== sv/lslf_pkg.sv =====
// Shared constants, codes and controller/datapath types of the line fit
`timescale 1ns / 1ps
`default_nettype none

package lslf_pkg;

  // Parameter defaults
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF    = 8;
  localparam int COUNT_WIDTH_DEF  = 20;

  // Fixed widths of sums, solver words and results
  localparam int SUM_LIN_W = 40;
  localparam int SUM_SQ_W  = 64;
  localparam int OPND_W    = 64;
  localparam int HALF_W    = OPND_W / 2;
  localparam int WIDE_W    = 128;
  localparam int RES_W     = 32;
  localparam int OUT_FRAC  = 16;

  // Sequential multiplier: four partial products, then sign fix
  localparam int MUL_CNT_W = 3;
  localparam logic [MUL_CNT_W-1:0] MUL_PP_STEPS  = MUL_CNT_W'(4);
  localparam logic [MUL_CNT_W-1:0] MUL_LAST_STEP = MUL_CNT_W'(5);

  // Restoring divider: one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(WIDE_W);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(WIDE_W - 1);

  // Product select codes, in solve order
  localparam int PROD_SEL_W = 3;
  typedef logic [PROD_SEL_W-1:0] prod_sel_t;
  localparam prod_sel_t PROD_DET_A = 3'd0;  // n * Sxx
  localparam prod_sel_t PROD_DET_B = 3'd1;  // Sx * Sx
  localparam prod_sel_t PROD_NA_A  = 3'd2;  // Sy * Sxx
  localparam prod_sel_t PROD_NA_B  = 3'd3;  // Sx * Sxy
  localparam prod_sel_t PROD_NB_A  = 3'd4;  // n * Sxy
  localparam prod_sel_t PROD_NB_B  = 3'd5;  // Sx * Sy

  // Divider result destination
  localparam logic PICK_INTERCEPT = 1'b0;
  localparam logic PICK_SLOPE     = 1'b1;

  // Commands from the controller
  typedef struct packed {
    logic      take;       // sample request accepted this cycle
    logic      mul_start;
    prod_sel_t sel;
    logic      res_clear;
    logic      div_start;
    logic      div_pick;
    logic      out_load;   // load output register and clear the sums
  } cmd_t;

  // Status back to the controller
  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic det_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== sv/lslf_mul.sv =====
// Sequential signed 64x64 multiplier built on one 32x32 partial product per cycle
`timescale 1ns / 1ps
`default_nettype none

module lslf_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [lslf_pkg::OPND_W-1:0]   a_i,
  input  logic [lslf_pkg::OPND_W-1:0]   b_i,
  output logic                          done_o,
  output logic [lslf_pkg::WIDE_W-1:0]   prod_o
);
  import lslf_pkg::*;

  logic                 busy_q, busy_d;
  logic [MUL_CNT_W-1:0] cnt_q, cnt_d;
  logic                 ppv_q, ppv_d;
  logic                 done_q, done_d;

  logic [OPND_W-1:0]    am_q, bm_q;
  logic                 neg_q;
  logic [OPND_W-1:0]    pp_q, pp_d;
  logic [1:0]           sh_q, sh_d;
  logic [WIDE_W-1:0]    acc_q;
  logic [WIDE_W-1:0]    prod_q;
  logic [HALF_W-1:0]    a_half, b_half;
  logic [WIDE_W-1:0]    pp_shift;

  // Pick the halves for this step and the weight of the partial product
  assign a_half = cnt_q[0] ? am_q[OPND_W-1:HALF_W] : am_q[HALF_W-1:0];
  assign b_half = cnt_q[1] ? bm_q[OPND_W-1:HALF_W] : bm_q[HALF_W-1:0];
  assign pp_d   = a_half * b_half;
  assign sh_d   = {1'b0, cnt_q[0]} + {1'b0, cnt_q[1]};

  always_comb begin
    unique case (sh_q)
      2'd0:    pp_shift = WIDE_W'(pp_q);
      2'd1:    pp_shift = WIDE_W'(pp_q) << HALF_W;
      2'd2:    pp_shift = WIDE_W'(pp_q) << OPND_W;
      default: pp_shift = '0;
    endcase
  end

  // Step sequencing
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    ppv_d  = 1'b0;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      ppv_d = (cnt_q < MUL_PP_STEPS);
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == MUL_LAST_STEP) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      ppv_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      ppv_q  <= ppv_d;
      done_q <= done_d;
    end
  end

  // Latch magnitudes, accumulate partial products, fix the sign at the end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= a_i[OPND_W-1] ? -a_i : a_i;
      bm_q  <= b_i[OPND_W-1] ? -b_i : b_i;
      neg_q <= a_i[OPND_W-1] ^ b_i[OPND_W-1];
      acc_q <= '0;
    end else if (ppv_q) begin
      acc_q <= acc_q + pp_shift;
    end
    if (busy_q && (cnt_q < MUL_PP_STEPS)) begin
      pp_q <= pp_d;
      sh_q <= sh_d;
    end
    if (busy_q && (cnt_q == MUL_LAST_STEP)) begin
      prod_q <= neg_q ? -acc_q : acc_q;
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ===== sv/lslf_div.sv =====
// Rounding signed divider, one quotient bit per cycle, saturating to 32 bits
`timescale 1ns / 1ps
`default_nettype none

module lslf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lslf_pkg::WIDE_W-1:0]  num_i,
  input  logic [lslf_pkg::WIDE_W-1:0]  den_i,
  output logic                         done_o,
  output logic [lslf_pkg::RES_W-1:0]   quo_o,
  output logic                         clip_o
);
  import lslf_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ABS  = 3'd1;
  localparam logic [2:0] PH_PREP = 3'd2;
  localparam logic [2:0] PH_ITER = 3'd3;
  localparam logic [2:0] PH_FIN  = 3'd4;

  localparam logic [RES_W-1:0] LIM_NEG = {1'b1, {(RES_W-1){1'b0}}};
  localparam logic [RES_W-1:0] LIM_POS = {1'b0, {(RES_W-1){1'b1}}};

  logic [2:0]           phase_q, phase_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 done_q, done_d;

  logic [WIDE_W-1:0]    nq_q;   // dividend shifting out, quotient shifting in
  logic [WIDE_W-1:0]    dv_q;
  logic [WIDE_W-1:0]    rem_q;
  logic                 neg_q;
  logic [RES_W-1:0]     quo_q;
  logic                 clip_q;

  logic [WIDE_W-1:0]    r_sh;
  logic [WIDE_W:0]      diff;
  logic                 ge;
  logic [RES_W-1:0]     lim;
  logic                 over;
  logic [RES_W-1:0]     mag;

  // One restoring step
  assign r_sh = {rem_q[WIDE_W-2:0], nq_q[WIDE_W-1]};
  assign diff = {1'b0, r_sh} - {1'b0, dv_q};
  assign ge   = !diff[WIDE_W];

  // Clip the rounded magnitude to the signed result range
  assign lim  = neg_q ? LIM_NEG : LIM_POS;
  assign over = (|nq_q[WIDE_W-1:RES_W]) || (nq_q[RES_W-1:0] > lim);
  assign mag  = over ? lim : nq_q[RES_W-1:0];

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    unique case (phase_q)
      PH_IDLE: if (start_i) phase_d = PH_ABS;
      PH_ABS:  phase_d = PH_PREP;
      PH_PREP: begin
        phase_d = PH_ITER;
        cnt_d   = '0;
      end
      PH_ITER: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST_STEP) phase_d = PH_FIN;
      end
      PH_FIN: begin
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      PH_IDLE: begin
        if (start_i) begin
          nq_q <= num_i;
          dv_q <= den_i;
        end
      end
      // Take magnitudes and the result sign
      PH_ABS: begin
        neg_q <= nq_q[WIDE_W-1] ^ dv_q[WIDE_W-1];
        nq_q  <= nq_q[WIDE_W-1] ? -nq_q : nq_q;
        dv_q  <= dv_q[WIDE_W-1] ? -dv_q : dv_q;
      end
      // Round to nearest: (2|n| + |d|) / (2|d|)
      PH_PREP: begin
        nq_q  <= {nq_q[WIDE_W-2:0], 1'b0} + dv_q;
        dv_q  <= {dv_q[WIDE_W-2:0], 1'b0};
        rem_q <= '0;
      end
      PH_ITER: begin
        rem_q <= ge ? diff[WIDE_W-1:0] : r_sh;
        nq_q  <= {nq_q[WIDE_W-2:0], ge};
      end
      PH_FIN: begin
        quo_q  <= neg_q ? -mag : mag;
        clip_q <= over;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign clip_o = clip_q;

endmodule

`default_nettype wire

// ===== sv/lslf_dp.sv =====
// Datapath: running sums, normal-equation products, divides and output register
`timescale 1ns / 1ps
`default_nettype none

module lslf_dp #(
  parameter int SAMPLE_WIDTH = lslf_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = lslf_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH  = lslf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic signed [SAMPLE_WIDTH-1:0]   x_i,
  input  logic signed [SAMPLE_WIDTH-1:0]   y_i,
  input  lslf_pkg::cmd_t                   cmd_i,
  output lslf_pkg::stat_t                  stat_o,
  input  logic                             m_ready_i,
  output logic                             m_valid_o,
  output logic [lslf_pkg::RES_W-1:0]       intercept_o,
  output logic [lslf_pkg::RES_W-1:0]       slope_o,
  output logic                             singular_o,
  output logic                             saturated_o,
  output logic [COUNT_WIDTH-1:0]           samples_used_o
);
  import lslf_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Running sums
  logic [COUNT_WIDTH-1:0]           cnt_q;
  logic signed [SUM_LIN_W-1:0]      sx_q, sy_q;
  logic [SUM_SQ_W-1:0]              sxy_q, sxx_q;
  logic                             add_en;
  logic signed [2*SAMPLE_WIDTH-1:0] pxy, pxx;
  logic [SUM_SQ_W-1:0]              pxy_q, pxx_q;
  logic                             prod_v_q;

  // Solver
  logic [OPND_W-1:0]                op_a, op_b;
  logic [OPND_W-1:0]                n_op, sx_op, sy_op;
  logic                             mul_done;
  logic [WIDE_W-1:0]                mul_prod;
  logic [WIDE_W-1:0]                det_q, na_q, nb_q;
  logic [WIDE_W-1:0]                div_num;
  logic                             div_done;
  logic [RES_W-1:0]                 div_quo;
  logic                             div_clip;
  logic [RES_W-1:0]                 icpt_q, slope_q;
  logic                             sat_q;

  // Output register
  logic                             m_valid_q;
  logic [RES_W-1:0]                 o_icpt_q, o_slope_q;
  logic                             o_sing_q, o_sat_q;
  logic [COUNT_WIDTH-1:0]           o_cnt_q;

  // Accumulate only while the count has room
  assign add_en = cmd_i.take && (cnt_q != COUNT_MAX);
  assign pxy    = x_i * y_i;
  assign pxx    = x_i * x_i;

  always_ff @(posedge clk_i) begin
    pxy_q <= SUM_SQ_W'(pxy);
    pxx_q <= SUM_SQ_W'(pxx);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      sxy_q     <= '0;
      sxx_q     <= '0;
      prod_v_q  <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      prod_v_q <= add_en;
      if (cmd_i.out_load) begin
        cnt_q <= '0;
        sx_q  <= '0;
        sy_q  <= '0;
        sxy_q <= '0;
        sxx_q <= '0;
      end else begin
        if (add_en) begin
          cnt_q <= cnt_q + 1'b1;
          sx_q  <= sx_q + SUM_LIN_W'(x_i);
          sy_q  <= sy_q + SUM_LIN_W'(y_i);
        end
        // Products are registered and land in the sums in the cycle after their request
        if (prod_v_q) begin
          sxy_q <= sxy_q + pxy_q;
          sxx_q <= sxx_q + pxx_q;
        end
      end
      if (cmd_i.out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Operand select for the shared multiplier
  assign n_op  = OPND_W'(cnt_q);
  assign sx_op = OPND_W'(sx_q);
  assign sy_op = OPND_W'(sy_q);

  always_comb begin
    unique case (cmd_i.sel)
      PROD_DET_A: begin op_a = n_op;  op_b = sxx_q; end
      PROD_DET_B: begin op_a = sx_op; op_b = sx_op; end
      PROD_NA_A:  begin op_a = sy_op; op_b = sxx_q; end
      PROD_NA_B:  begin op_a = sx_op; op_b = sxy_q; end
      PROD_NB_A:  begin op_a = n_op;  op_b = sxy_q; end
      PROD_NB_B:  begin op_a = sx_op; op_b = sy_op; end
      default:    begin op_a = '0;    op_b = '0;    end
    endcase
  end

  lslf_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  // Build determinant and both numerators as product differences
  always_ff @(posedge clk_i) begin
    if (mul_done) begin
      unique case (cmd_i.sel)
        PROD_DET_A: det_q <= mul_prod;
        PROD_DET_B: det_q <= det_q - mul_prod;
        PROD_NA_A:  na_q  <= mul_prod;
        PROD_NA_B:  na_q  <= na_q - mul_prod;
        PROD_NB_A:  nb_q  <= mul_prod;
        PROD_NB_B:  nb_q  <= nb_q - mul_prod;
        default: ;
      endcase
    end
  end

  // Scale numerators to Q16.16 before dividing by the determinant
  assign div_num = (cmd_i.div_pick == PICK_SLOPE) ? (nb_q << OUT_FRAC)
                                                  : (na_q << (OUT_FRAC - FRAC_BITS));

  lslf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (det_q),
    .done_o  (div_done),
    .quo_o   (div_quo),
    .clip_o  (div_clip)
  );

  // Collect the fit results
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_clear) begin
      icpt_q  <= '0;
      slope_q <= '0;
      sat_q   <= 1'b0;
    end else if (div_done) begin
      if (cmd_i.div_pick == PICK_SLOPE) begin
        slope_q <= div_quo;
      end else begin
        icpt_q <= div_quo;
      end
      sat_q <= sat_q | div_clip;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      o_icpt_q  <= icpt_q;
      o_slope_q <= slope_q;
      o_sing_q  <= (det_q == '0);
      o_sat_q   <= sat_q;
      o_cnt_q   <= cnt_q;
    end
  end

  assign stat_o.mul_done = mul_done;
  assign stat_o.div_done = div_done;
  assign stat_o.det_zero = (det_q == '0);
  assign stat_o.out_free = !m_valid_q || m_ready_i;

  assign m_valid_o      = m_valid_q;
  assign intercept_o    = o_icpt_q;
  assign slope_o        = o_slope_q;
  assign singular_o     = o_sing_q;
  assign saturated_o    = o_sat_q;
  assign samples_used_o = o_cnt_q;

endmodule

`default_nettype wire

// ===== sv/lslf_ctrl.sv =====
// Controller: sample intake, solve sequencing and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module lslf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_valid_i,
  input  logic             s_last_i,
  output logic             s_ready_o,
  input  lslf_pkg::stat_t  stat_i,
  output lslf_pkg::cmd_t   cmd_o
);
  import lslf_pkg::*;

  localparam logic [3:0] ST_ACC        = 4'd0;
  localparam logic [3:0] ST_DRAIN      = 4'd1;
  localparam logic [3:0] ST_MUL        = 4'd2;
  localparam logic [3:0] ST_MUL_WAIT   = 4'd3;
  localparam logic [3:0] ST_CHECK      = 4'd4;
  localparam logic [3:0] ST_DIV_A      = 4'd5;
  localparam logic [3:0] ST_DIV_A_WAIT = 4'd6;
  localparam logic [3:0] ST_DIV_B      = 4'd7;
  localparam logic [3:0] ST_DIV_B_WAIT = 4'd8;
  localparam logic [3:0] ST_OUT        = 4'd9;

  logic [3:0] state_q, state_d;
  prod_sel_t  sel_q, sel_d;

  assign s_ready_o = (state_q == ST_ACC);

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    cmd_o   = '0;
    cmd_o.sel = sel_q;
    unique case (state_q)
      // Take sample requests until the last one of the set
      ST_ACC: begin
        cmd_o.take = s_valid_i;
        if (s_valid_i && s_last_i) state_d = ST_DRAIN;
      end
      // Let the last products reach the sums
      ST_DRAIN: begin
        sel_d   = PROD_DET_A;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_start = 1'b1;
        state_d         = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (stat_i.mul_done) begin
          if (sel_q == PROD_NB_B) begin
            state_d = ST_CHECK;
          end else begin
            sel_d   = sel_q + 1'b1;
            state_d = ST_MUL;
          end
        end
      end
      // Skip the divides on a zero determinant
      ST_CHECK: begin
        cmd_o.res_clear = 1'b1;
        state_d = stat_i.det_zero ? ST_OUT : ST_DIV_A;
      end
      ST_DIV_A: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_pick  = PICK_INTERCEPT;
        state_d         = ST_DIV_A_WAIT;
      end
      ST_DIV_A_WAIT: begin
        cmd_o.div_pick = PICK_INTERCEPT;
        if (stat_i.div_done) state_d = ST_DIV_B;
      end
      ST_DIV_B: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_pick  = PICK_SLOPE;
        state_d         = ST_DIV_B_WAIT;
      end
      ST_DIV_B_WAIT: begin
        cmd_o.div_pick = PICK_SLOPE;
        if (stat_i.div_done) state_d = ST_OUT;
      end
      // Hand the result over once the output register is free
      ST_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: state_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
      sel_q   <= PROD_DET_A;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/least_squares_line_fit.sv =====
// Top level of the least-squares straight-line fit y = a + b*x.
// Sample channel (s_axis): one (x, y) pair per request, signed with FRAC_BITS
// fraction bits; tlast marks the final sample of a set. While collecting, one
// request is taken every cycle; the count and the sums of x, y, x*y and x*x
// are updated, and once the count is full further samples are dropped.
// After the last sample, tready stays low while the 2x2 normal equations are
// solved: six 64x64 products on a shared 32x32 multiplier, then two 128-bit
// restoring divides, one quotient bit per cycle.
// Result channel (m_axis): intercept and slope in Q16.16, rounded to nearest
// and saturated, plus the sample count; tuser flags singular and saturated.
// The result sits in an output register: if the receiver stalls, the block
// still collects the next set and only waits when the next result is ready.
// Reset clears the count, the sums and all pending requests and results.
`timescale 1ns / 1ps
`default_nettype none
`include "least_squares_line_fit_assert.svh"

module least_squares_line_fit #(
  parameter int SAMPLE_WIDTH = lslf_pkg::SAMPLE_WIDTH_DEF,
  parameter int FRAC_BITS    = lslf_pkg::FRAC_BITS_DEF,
  parameter int COUNT_WIDTH  = lslf_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  // x_sample, y_sample
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]              s_axis_tdata,
  // last_sample
  input  logic                                             s_axis_tlast,
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  // intercept, slope, samples_used
  output logic [((2*lslf_pkg::RES_W+COUNT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // singular, saturated
  output logic [1:0]                                       m_axis_tuser
);
  import lslf_pkg::*;

  localparam int M_TDATA_W = ((2*RES_W + COUNT_WIDTH + 7) / 8) * 8;

  cmd_t                   cmd;
  stat_t                  stat;
  logic [RES_W-1:0]       intercept;
  logic [RES_W-1:0]       slope;
  logic                   singular;
  logic                   saturated;
  logic [COUNT_WIDTH-1:0] samples_used;

  lslf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  lslf_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .x_i            (s_axis_tdata[SAMPLE_WIDTH-1:0]),
    .y_i            (s_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .m_ready_i      (m_axis_tready),
    .m_valid_o      (m_axis_tvalid),
    .intercept_o    (intercept),
    .slope_o        (slope),
    .singular_o     (singular),
    .saturated_o    (saturated),
    .samples_used_o (samples_used)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = M_TDATA_W'({samples_used, slope, intercept});
  assign m_axis_tuser = {saturated, singular};

  // A singular fit carries zero results and no clip flag
  `LSLF_ASSERT_IMPLIES(a_singular_zero, clk_i, rst_ni, m_axis_tvalid && singular, intercept == '0 && slope == '0 && !saturated)
  // The last sample of a set stops intake until the solve is done
  `LSLF_ASSERT_NEXT(a_last_stops_intake, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)
  // Every fit covers at least one sample
  `LSLF_ASSERT_IMPLIES(a_fit_has_samples, clk_i, rst_ni, m_axis_tvalid, samples_used != '0)

endmodule

`default_nettype wire
